@@ rtl/core/fba_pkg.sv @@
// Shared types, constants and status codes for the frame bitmap allocator.
package fba_pkg;

    // Default sizing of the frame bitmap.
    localparam int NUM_FRAMES_DEF  = 4096;
    localparam int WORD_BITS_DEF   = 32;
    localparam int FRAME_SHIFT_DEF = 12;

    // Frame count register.
    localparam int                  FRAME_COUNT_W   = 13;
    localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RST = 13'd4096;

    // Item kinds.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] STAT_ALLOCATED = 2'd0;
    localparam logic [1:0] STAT_MAPPED    = 2'd1;
    localparam logic [1:0] STAT_NO_MEMORY = 2'd2;
    localparam logic [1:0] STAT_FREED     = 2'd3;

    // One command item.
    typedef struct packed {
        logic        kind;
        logic [19:0] page_frame;
        logic        kernel_page;
        logic        rw_page;
        logic [31:0] free_address;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] frame_number;
        logic        present;
        logic        user;
        logic        writable;
    } out_item_t;

    // Status of one bitmap word scan.
    typedef struct packed {
        logic found;      // A free frame below the limit sits in this word.
        logic last;       // No later word holds a frame below the limit.
        logic full_after; // The word has no clear bit once the grant is applied.
    } scan_flags_t;

endpackage

@@ rtl/core/fba_word_scan.sv @@
// Lowest free frame search within one bitmap word, bounded by the frame limit.
module fba_word_scan
    import fba_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FB_W      = 8,
    parameter int LIM_W     = 13
)(
    input  logic [WORD_BITS-1:0]         word_data,
    input  logic [FB_W-1:0]              base,
    input  logic [LIM_W-1:0]             limit,
    output logic [$clog2(WORD_BITS)-1:0] bit_index,
    output logic [WORD_BITS-1:0]         word_new,
    output scan_flags_t                  flags
);

    localparam int WS = $clog2(WORD_BITS);
    localparam int CW = ((FB_W > LIM_W) ? FB_W : LIM_W) + 1;

    logic [WORD_BITS-1:0] in_range;
    logic [WORD_BITS-1:0] avail;
    logic [WORD_BITS-1:0] lowest;

    // A bit counts only if its frame index lies below the limit.
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            in_range[b] = (CW'(base) + CW'(b)) < CW'(limit);
        end
    end

    assign avail  = ~word_data & in_range;
    assign lowest = avail & (~avail + WORD_BITS'(1));

    // Priority encoder for the lowest available bit.
    always_comb
    begin
        bit_index = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (avail[b])
            begin
                bit_index = WS'(b);
            end
        end
    end

    assign word_new         = word_data | lowest;
    assign flags.found      = |avail;
    assign flags.last       = (CW'(base) + CW'(WORD_BITS)) >= CW'(limit);
    assign flags.full_after = &word_new;

endmodule

@@ rtl/core/frame_bitmap_allocator_unit.sv @@
// Top level of the first-fit bitmap allocator of physical page frames.
//
//  Channel   Ports                    Transfer rule
//  --------  -----------------------  -------------------------------------------
//  command   start, busy, item        taken at a clock edge with start high, busy low
//  result    done, result             valid for the one cycle that done is high
//  config    cfg_wen, cfg_wdata       frame_count written at an edge with cfg_wen high
//
// After reset the bitmap memory is swept clear, one word per cycle, and busy
// stays high until all MAP_WORDS words are clear. An already mapped allocate,
// an out-of-range free or an allocate whose search hint is past the limit
// answer in the cycle after the transfer. A free reads its word, then writes it
// back. An allocate reads words from the search hint upward until one holds a
// free frame below the limit or none is left; a search hint skips the run of
// full words at the bottom of the map. The result strobe cannot be held off,
// and a new command is taken in the same cycle that done is high.
module frame_bitmap_allocator_unit
    import fba_pkg::*;
#(
    parameter int NUM_FRAMES  = NUM_FRAMES_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF,  // power of two
    parameter int FRAME_SHIFT = FRAME_SHIFT_DEF
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  in_item_t                 item,
    input  logic                     cfg_wen,
    input  logic [FRAME_COUNT_W-1:0] cfg_wdata,
    output logic                     done,
    output out_item_t                result
);

    localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WS        = $clog2(WORD_BITS);
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int HINT_W    = $clog2(MAP_WORDS + 1);
    localparam int FB_W      = HINT_W + WS;
    localparam int LIM_W     = $clog2(NUM_FRAMES + 1);
    localparam int CW        = ((FB_W > LIM_W) ? FB_W : LIM_W) + 1;
    localparam int FA_W      = 32 - FRAME_SHIFT;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_WORDS - 1);

    // Controller states.
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_ALLOC = 2'd2;
    localparam logic [1:0] S_FREE  = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [ADDR_W-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [HINT_W-1:0]        hint_reg, hint_next;
    logic [HINT_W-1:0]        word_reg, word_next;
    logic [WS-1:0]            bit_reg, bit_next;
    logic                     user_reg, user_next;
    logic                     wr_reg, wr_next;
    logic [FRAME_COUNT_W-1:0] frame_count_reg;
    logic                     done_reg, done_next;
    out_item_t                result_reg, result_next;

    // Bitmap memory and its port signals.
    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 mem_rd_en;
    logic [ADDR_W-1:0]    mem_rd_addr;
    logic                 mem_wr_en;
    logic [ADDR_W-1:0]    mem_wr_addr;
    logic [WORD_BITS-1:0] mem_wr_data;

    logic [LIM_W-1:0]       limit;
    logic [FB_W-1:0]        word_base;
    logic [FB_W-1:0]        hint_base;
    logic [WS-1:0]          scan_bit;
    logic [WORD_BITS-1:0]   scan_word;
    scan_flags_t            scan_flags;
    logic [FA_W-1:0]        free_frame;
    logic [FA_W+HINT_W-1:0] free_frame_ext;
    logic [FB_W+11:0]       grant_ext;

    // Frame limit: the configured count, capped at the map size.
    always_comb
    begin
        if (32'(frame_count_reg) > NUM_FRAMES)
        begin
            limit = LIM_W'(NUM_FRAMES);
        end
        else
        begin
            limit = LIM_W'(frame_count_reg);
        end
    end

    assign word_base      = {word_reg, {WS{1'b0}}};
    assign hint_base      = {hint_reg, {WS{1'b0}}};
    assign free_frame     = item.free_address[31:FRAME_SHIFT];
    assign free_frame_ext = {{HINT_W{1'b0}}, free_frame};
    assign grant_ext      = {12'd0, word_reg, scan_bit};

    // Search of the word just read.
    fba_word_scan #(
        .WORD_BITS (WORD_BITS),
        .FB_W      (FB_W),
        .LIM_W     (LIM_W)
    ) u_scan (
        .word_data (rd_data_reg),
        .base      (word_base),
        .limit     (limit),
        .bit_index (scan_bit),
        .word_new  (scan_word),
        .flags     (scan_flags)
    );

    // Controller: clearing sweep, command decode, read-modify-write of the bitmap.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        hint_next    = hint_reg;
        word_next    = word_reg;
        bit_next     = bit_reg;
        user_next    = user_reg;
        wr_next      = wr_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = word_reg[ADDR_W-1:0];
        mem_wr_en    = 1'b0;
        mem_wr_addr  = word_reg[ADDR_W-1:0];
        mem_wr_data  = scan_word;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en    = 1'b1;
                mem_wr_addr  = clr_cnt_reg;
                mem_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    if (item.kind == KIND_FREE)
                    begin
                        word_next = free_frame_ext[WS +: HINT_W];
                        bit_next  = free_frame[WS-1:0];
                        if (free_frame < NUM_FRAMES)
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = free_frame_ext[WS +: ADDR_W];
                            state_next  = S_FREE;
                        end
                        else
                        begin
                            result_next        = '0;
                            result_next.status = STAT_FREED;
                            done_next          = 1'b1;
                        end
                    end
                    else if (item.page_frame != '0)
                    begin
                        result_next        = '0;
                        result_next.status = STAT_MAPPED;
                        done_next          = 1'b1;
                    end
                    else if (CW'(hint_base) >= CW'(limit))
                    begin
                        result_next        = '0;
                        result_next.status = STAT_NO_MEMORY;
                        done_next          = 1'b1;
                    end
                    else
                    begin
                        user_next   = ~item.kernel_page;
                        wr_next     = item.rw_page;
                        word_next   = hint_reg;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = hint_reg[ADDR_W-1:0];
                        state_next  = S_ALLOC;
                    end
                end
            end

            S_ALLOC:
            begin
                // Words below the hint are known full; move it past a full word.
                if ((word_reg == hint_reg) && scan_flags.full_after)
                begin
                    hint_next = hint_reg + HINT_W'(1);
                end
                if (scan_flags.found)
                begin
                    mem_wr_en                = 1'b1;
                    result_next              = '0;
                    result_next.status       = STAT_ALLOCATED;
                    result_next.frame_number = grant_ext[11:0];
                    result_next.present      = 1'b1;
                    result_next.user         = user_reg;
                    result_next.writable     = wr_reg;
                    done_next                = 1'b1;
                    state_next               = S_IDLE;
                end
                else if (scan_flags.last)
                begin
                    result_next        = '0;
                    result_next.status = STAT_NO_MEMORY;
                    done_next          = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    word_next   = word_reg + HINT_W'(1);
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = word_next[ADDR_W-1:0];
                end
            end

            S_FREE:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = rd_data_reg & ~(WORD_BITS'(1) << bit_reg);
                if (word_reg < hint_reg)
                begin
                    hint_next = word_reg;
                end
                result_next        = '0;
                result_next.status = STAT_FREED;
                done_next          = 1'b1;
                state_next         = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Bitmap memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= mem[mem_rd_addr];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            hint_reg        <= '0;
            done_reg        <= 1'b0;
            frame_count_reg <= FRAME_COUNT_RST;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            hint_reg    <= hint_next;
            done_reg    <= done_next;
            if (cfg_wen)
            begin
                frame_count_reg <= cfg_wdata;
            end
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        bit_reg    <= bit_next;
        user_reg   <= user_next;
        wr_reg     <= wr_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ verif/tb_frame_bitmap_allocator_unit.sv @@
// Self-checking testbench for the first-fit page frame bitmap allocator.
`timescale 1ns / 1ps

module tb_frame_bitmap_allocator_unit;
    import fba_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned TAIL_CYCLES   = 200;
    localparam int unsigned RANDOM_PHASES = 15;
    localparam int unsigned PHASE_ITEMS   = 100;
    localparam int unsigned MAP_WORDS     = NUM_FRAMES_DEF / WORD_BITS_DEF;

    // Kinds of entries in the stimulus queue.
    typedef enum logic [1:0] {
        JOB_CMD,
        JOB_SET_COUNT,
        JOB_DRAIN
    } job_op_e;

    typedef struct packed {
        job_op_e                  op;
        in_item_t                 cmd;
        logic [FRAME_COUNT_W-1:0] count;
    } job_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    in_item_t                 item = '0;
    logic                     cfg_wen = 1'b0;
    logic [FRAME_COUNT_W-1:0] cfg_wdata = '0;
    logic                     done;
    out_item_t                result;

    job_t        pending_jobs[$];
    out_item_t   grants_due[$];
    int unsigned error_count = 0;
    int unsigned sent_count = 0;
    int unsigned clock_ticks = 0;

    // Shadow copy of the frame bitmap and of the frame count register.
    logic [WORD_BITS_DEF-1:0] used_frames [MAP_WORDS];
    logic [FRAME_COUNT_W-1:0] managed_frames = FRAME_COUNT_RST;

    frame_bitmap_allocator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one command to the shadow bitmap and returns the answer it should get.
    function automatic out_item_t grant_or_release(input in_item_t cmd);
        out_item_t   answer;
        int unsigned limit;
        int unsigned frame;
        bit          found;
        answer = '0;
        found  = 1'b0;
        if (cmd.kind == KIND_FREE)
        begin
            frame = cmd.free_address >> FRAME_SHIFT_DEF;
            if (frame < NUM_FRAMES_DEF)
                used_frames[frame / WORD_BITS_DEF][frame % WORD_BITS_DEF] = 1'b0;
            answer.status = STAT_FREED;
        end
        else if (cmd.page_frame != '0)
        begin
            answer.status = STAT_MAPPED;
        end
        else
        begin
            limit = (managed_frames > NUM_FRAMES_DEF) ? NUM_FRAMES_DEF : managed_frames;
            answer.status = STAT_NO_MEMORY;
            for (frame = 0; frame < limit && !found; frame++)
            begin
                if (!used_frames[frame / WORD_BITS_DEF][frame % WORD_BITS_DEF])
                begin
                    used_frames[frame / WORD_BITS_DEF][frame % WORD_BITS_DEF] = 1'b1;
                    found               = 1'b1;
                    answer.status       = STAT_ALLOCATED;
                    answer.frame_number = frame[11:0];
                    answer.present      = 1'b1;
                    answer.user         = ~cmd.kernel_page;
                    answer.writable     = cmd.rw_page;
                end
            end
        end
        return answer;
    endfunction

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic queue_cmd(input logic kind, input logic [19:0] page_frame,
                             input logic kernel_page, input logic rw_page,
                             input logic [31:0] free_address);
        job_t job;
        job.op    = JOB_CMD;
        job.cmd   = '{kind, page_frame, kernel_page, rw_page, free_address};
        job.count = '0;
        pending_jobs.push_back(job);
    endtask

    task automatic queue_count(input logic [FRAME_COUNT_W-1:0] count);
        job_t job;
        job.op    = JOB_SET_COUNT;
        job.cmd   = '0;
        job.count = count;
        pending_jobs.push_back(job);
    endtask

    task automatic queue_drain();
        job_t job;
        job.op    = JOB_DRAIN;
        job.cmd   = '0;
        job.count = '0;
        pending_jobs.push_back(job);
    endtask

    // Mostly fresh allocations and frees of low frames, plus mapped entries and stray frees.
    task automatic queue_random_cmd(input int unsigned free_span);
        int unsigned roll;
        logic [31:0] frame;
        logic [31:0] addr;
        roll  = $urandom_range(99);
        addr  = $urandom();
        frame = $urandom_range(free_span - 1);
        if (roll < 55)
            queue_cmd(KIND_ALLOC, 20'd0, 1'($urandom_range(1)), 1'($urandom_range(1)), addr);
        else if (roll < 65)
            queue_cmd(KIND_ALLOC, 20'($urandom_range(20'hFFFFF, 1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), addr);
        else if (roll < 95)
            queue_cmd(KIND_FREE, 20'($urandom()), 1'($urandom_range(1)),
                      1'($urandom_range(1)), {frame[19:0], 12'($urandom_range(4095))});
        else
            queue_cmd(KIND_FREE, 20'($urandom()), 1'($urandom_range(1)),
                      1'($urandom_range(1)), addr);
    endtask

    // Shadow bitmap starts clear, as the block does after its sweep.
    initial
    begin
        for (int w = 0; w < MAP_WORDS; w++)
            used_frames[w] = '0;
    end

    // Command driver: holds start until the transfer, writes the count register when quiet.
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic next_start;
        logic next_cfg;
        bit   quiet;
        bit   gaps_on;
        job_t job;
        if (!rst_n)
        begin
            start   <= 1'b0;
            cfg_wen <= 1'b0;
        end
        else if (!(start && busy))
        begin
            next_start = 1'b0;
            next_cfg   = 1'b0;
            quiet      = !start && !busy && !done && !cfg_wen && grants_due.size() == 0;
            gaps_on    = !(sent_count >= 600 && sent_count < 900);
            if (pending_jobs.size() != 0 && !cfg_wen)
            begin
                job = pending_jobs[0];
                case (job.op)
                    JOB_CMD:
                    begin
                        if (!gaps_on || $urandom_range(99) >= 35)
                        begin
                            next_start = 1'b1;
                            item      <= job.cmd;
                            sent_count++;
                            void'(pending_jobs.pop_front());
                        end
                    end
                    JOB_SET_COUNT:
                    begin
                        if (quiet)
                        begin
                            next_cfg   = 1'b1;
                            cfg_wdata <= job.count;
                            void'(pending_jobs.pop_front());
                        end
                    end
                    default:
                    begin
                        if (quiet)
                            void'(pending_jobs.pop_front());
                    end
                endcase
            end
            start   <= next_start;
            cfg_wen <= next_cfg;
        end
    end

    // Monitor: checks each result strobe, then predicts any command transfer.
    always @(posedge clk)
    begin : monitor
        out_item_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (grants_due.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, actual status %0d frame %0d",
                             $time, result.status, result.frame_number);
                end
                else
                begin
                    want = grants_due.pop_front();
                    report_field("status", want.status, result.status);
                    report_field("frame_number", want.frame_number, result.frame_number);
                    report_field("present", want.present, result.present);
                    report_field("user", want.user, result.user);
                    report_field("writable", want.writable, result.writable);
                end
            end
            if (start && !busy)
                grants_due.push_back(grant_or_release(item));
            if (cfg_wen)
                managed_frames = cfg_wdata;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        clock_ticks <= clock_ticks + 1;
        if (clock_ticks == CYCLE_LIMIT)
        begin
            $display("tb_frame_bitmap_allocator_unit: errors");
            $finish;
        end
    end

    // Stimulus, reset and end of test.
    initial
    begin
        int unsigned              span;
        logic [FRAME_COUNT_W-1:0] count;

        // Directed part, first with the count left at its reset value.
        queue_cmd(KIND_ALLOC, 20'd0, 1'b1, 1'b0, 32'd0);
        queue_cmd(KIND_ALLOC, 20'd0, 1'b0, 1'b1, 32'd0);
        queue_cmd(KIND_ALLOC, 20'hFFFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
        queue_cmd(KIND_ALLOC, 20'd1, 1'b0, 1'b0, 32'd0);
        queue_cmd(KIND_FREE, 20'd0, 1'b0, 1'b0, 32'h0000_0ABC);
        queue_cmd(KIND_FREE, 20'hFFFFF, 1'b1, 1'b1, 32'h00FF_F000);
        queue_cmd(KIND_FREE, 20'd0, 1'b0, 1'b0, 32'hFFFF_FFFF);
        queue_cmd(KIND_FREE, 20'd0, 1'b0, 1'b0, 32'h0100_0000);
        queue_cmd(KIND_ALLOC, 20'd0, 1'b1, 1'b1, 32'd0);
        // No frames managed at all.
        queue_count(13'd0);
        queue_cmd(KIND_ALLOC, 20'd0, 1'b0, 1'b1, 32'd0);
        queue_cmd(KIND_ALLOC, 20'd0, 1'b0, 1'b0, 32'd0);
        // Tiny pool that runs dry.
        queue_count(13'd3);
        queue_cmd(KIND_ALLOC, 20'd0, 1'b1, 1'b0, 32'd0);
        queue_cmd(KIND_ALLOC, 20'd0, 1'b1, 1'b0, 32'd0);
        // A count above capacity is clamped to the bitmap size.
        queue_count(13'h1FFF);
        queue_cmd(KIND_ALLOC, 20'd0, 1'b0, 1'b1, 32'd0);
        // Free of a frame above the count still clears its bit.
        queue_count(13'd2);
        queue_cmd(KIND_FREE, 20'd0, 1'b0, 1'b0, 32'h0000_3FFF);
        queue_count(FRAME_COUNT_RST);
        queue_cmd(KIND_ALLOC, 20'd0, 1'b0, 1'b0, 32'd0);
        queue_cmd(KIND_FREE, 20'd0, 1'b0, 1'b0, 32'd0);
        queue_cmd(KIND_ALLOC, 20'd0, 1'b1, 1'b1, 32'd0);

        // Random part in phases, each with its own frame count.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       count = FRAME_COUNT_RST;
                1:       count = 13'h1FFF;
                2:       count = 13'd0;
                3:       count = 13'd1;
                4:       count = 13'd33;
                5:       count = 13'd40;
                default:
                begin
                    case ($urandom_range(3))
                        0:       count = FRAME_COUNT_W'($urandom_range(200, 1));
                        1:       count = FRAME_COUNT_W'($urandom_range(1000, 200));
                        2:       count = FRAME_COUNT_W'(WORD_BITS_DEF * $urandom_range(8, 1));
                        default: count = FRAME_COUNT_W'($urandom_range(13'h1FFF));
                    endcase
                end
            endcase
            queue_count(count);
            span = (count > NUM_FRAMES_DEF) ? NUM_FRAMES_DEF : count;
            span = ((span > 600) ? 600 : span) + 8;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                queue_random_cmd(span);
                if (p == 7 && n == 50)
                    queue_drain();
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_jobs.size() != 0 || start || grants_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_frame_bitmap_allocator_unit: clean");
        else
            $display("tb_frame_bitmap_allocator_unit: errors");
        $finish;
    end

endmodule
